>>> hw/rtl/four_level_page_table_walker_assert.svh
// ----------------------------------------------------------------------------
// Page table walker assertion macros
// Shorthand for clocked checks that the walker top level uses. Every check
// samples on clock and is switched off while reset is high.
// ----------------------------------------------------------------------------
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define PGW_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check that cons holds in the cycle after ante
`define PGW_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> hw/rtl/pgwalk_pkg.sv
// ----------------------------------------------------------------------------
// Page table walker package
// Widths, entry bit positions, payload and command types, level codes and
// small helpers shared by the walker front end, back end and top level.
// ----------------------------------------------------------------------------
package pgwalk_pkg;

   // Table memory geometry
   localparam int MEM_WORDS = 4096;
   localparam int MEM_AW    = $clog2(MEM_WORDS);

   // Field widths
   localparam int WORD_W  = 64;
   localparam int WADDR_W = 12;
   localparam int ROOT_W  = 52;
   localparam int GFN_W   = 36;
   localparam int FRAME_W = 41;
   localparam int IDX_W   = 9;
   localparam int PAGE_SH = 12;
   localparam int TBL_W   = ROOT_W - PAGE_SH;   // entry bits 51..12
   localparam int WALK_W  = TBL_W + IDX_W;      // full word index of an entry

   // Entry bit positions
   localparam int BIT_PRESENT = 0;
   localparam int BIT_SIZE    = 7;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Opcodes of a request
   localparam logic OPC_WRITE = 1'b0;
   localparam logic OPC_WALK  = 1'b1;

   // Level codes: counter value is level number minus one
   localparam logic [1:0] LVL_TOP   = 2'd3;
   localparam logic [1:0] LVL_THREE = 2'd2;
   localparam logic [1:0] LVL_TWO   = 2'd1;
   localparam logic [1:0] LVL_ONE   = 2'd0;

   typedef struct packed {
      logic               opcode;
      logic [WADDR_W-1:0] word_address;
      logic [WORD_W-1:0]  write_data;
      logic [ROOT_W-1:0]  root_address;
      logic [GFN_W-1:0]   guest_frame;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [FRAME_W-1:0] machine_frame;
   } rsp_type;

   // Classified command as it sits in the queue
   typedef struct packed {
      logic              is_walk;
      logic [MEM_AW-1:0] waddr;
      logic [WORD_W-1:0] wdata;
      logic [TBL_W-1:0]  root_tbl;
      logic [GFN_W-1:0]  gfn;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic              we;
      logic [MEM_AW-1:0] waddr;
      logic [WORD_W-1:0] wdata;
      logic              re;
      logic [MEM_AW-1:0] raddr;
   } ram_req_type;

   typedef struct packed {
      logic busy;
      logic result_load;
   } back_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } walk_state_type;

   // True when a full entry word index falls inside the table memory
   function automatic logic in_mem(input logic [WALK_W-1:0] word);
      return word < WALK_W'(MEM_WORDS);
   endfunction

   // Guest frame bits that index the table at a given level
   function automatic logic [IDX_W-1:0] idx_of(input logic [GFN_W-1:0] gfn,
                                               input logic [1:0] lvl);
      logic [IDX_W-1:0] r;
      case (lvl)
         LVL_TOP:   r = gfn[4*IDX_W-1:3*IDX_W];
         LVL_THREE: r = gfn[3*IDX_W-1:2*IDX_W];
         LVL_TWO:   r = gfn[2*IDX_W-1:IDX_W];
         default:   r = gfn[IDX_W-1:0];
      endcase
      return r;
   endfunction

endpackage

>>> hw/rtl/pgwalk_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered and holds its
// value in cycles without a read.
// ----------------------------------------------------------------------------
module pgwalk_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and read storage
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/pgwalk_front.sv
// ----------------------------------------------------------------------------
// Page table walker front end
// Accepts requests, classifies them into table writes and walks, drops
// writes outside the table memory and queues the rest for the back end.
// ----------------------------------------------------------------------------
module pgwalk_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  pgwalk_pkg::req_type        req_data,
   output pgwalk_pkg::queue_head_type head,
   input  logic                       pop
);

   pgwalk_pkg::cmd_type               q_ff [pgwalk_pkg::QUEUE_DEPTH];
   logic [pgwalk_pkg::QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pgwalk_pkg::QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pgwalk_pkg::QUEUE_CW-1:0]   count_ff, count_in;
   pgwalk_pkg::cmd_type               cmd;
   logic                              accept;
   logic                              keep;
   logic                              push;
   logic                              do_pop;

   // Classify the incoming request
   always_comb begin
      cmd.is_walk  = (req_data.opcode == pgwalk_pkg::OPC_WALK);
      cmd.waddr    = pgwalk_pkg::MEM_AW'(req_data.word_address);
      cmd.wdata    = req_data.write_data;
      cmd.root_tbl = req_data.root_address[pgwalk_pkg::ROOT_W-1:pgwalk_pkg::PAGE_SH];
      cmd.gfn      = req_data.guest_frame;
      keep = cmd.is_walk ||
             pgwalk_pkg::in_mem(pgwalk_pkg::WALK_W'(req_data.word_address));
   end

   assign req_stall = (count_ff == pgwalk_pkg::QUEUE_CW'(pgwalk_pkg::QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign push      = accept && keep;
   assign do_pop    = pop && (count_ff != '0);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store queued commands
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.cmd   = q_ff[rd_ptr_ff];

endmodule

>>> hw/rtl/pgwalk_back.sv
// ----------------------------------------------------------------------------
// Page table walker back end
// Executes queued commands: stores table writes, walks up to four table
// levels one memory read per level, and holds the result in an output
// register until it is taken.
// ----------------------------------------------------------------------------
module pgwalk_back (
   input  logic                        clock,
   input  logic                        reset,
   input  pgwalk_pkg::queue_head_type  head,
   output logic                        pop,
   output pgwalk_pkg::ram_req_type     ram_req,
   input  logic [pgwalk_pkg::WORD_W-1:0] ram_rdata,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output pgwalk_pkg::rsp_type         rsp_data,
   output pgwalk_pkg::back_status_type status
);

   pgwalk_pkg::walk_state_type        state_ff, state_in;
   logic [1:0]                        level_ff, level_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   pgwalk_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                              rsp_free;
   logic [pgwalk_pkg::WALK_W-1:0]     first_word;
   logic                              first_ok;
   logic [pgwalk_pkg::WALK_W-1:0]     next_word;
   logic                              next_ok;
   logic [pgwalk_pkg::TBL_W-1:0]      ent_tbl;
   logic                              present;
   logic                              big_page;
   logic                              done_leaf;
   logic                              finish;
   logic [pgwalk_pkg::FRAME_W-1:0]    leaf_frame;
   logic                              load;
   pgwalk_pkg::rsp_type               result;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Decode the entry that came back and the next word to fetch
   always_comb begin
      first_word = {head.cmd.root_tbl,
                    pgwalk_pkg::idx_of(head.cmd.gfn, pgwalk_pkg::LVL_TOP)};
      first_ok   = pgwalk_pkg::in_mem(first_word);
      ent_tbl    = ram_rdata[pgwalk_pkg::ROOT_W-1:pgwalk_pkg::PAGE_SH];
      present    = ram_rdata[pgwalk_pkg::BIT_PRESENT];
      big_page   = ram_rdata[pgwalk_pkg::BIT_SIZE] && (level_ff == pgwalk_pkg::LVL_TWO);
      next_word  = {ent_tbl, pgwalk_pkg::idx_of(head.cmd.gfn, level_ff - 2'd1)};
      next_ok    = pgwalk_pkg::in_mem(next_word);
      done_leaf  = present && ((level_ff == pgwalk_pkg::LVL_ONE) || big_page);
      finish     = !present || done_leaf || !next_ok;
      leaf_frame = pgwalk_pkg::FRAME_W'(ent_tbl);
      if (big_page) begin
         leaf_frame = pgwalk_pkg::FRAME_W'(ent_tbl) +
                      pgwalk_pkg::FRAME_W'(head.cmd.gfn[pgwalk_pkg::IDX_W-1:0]);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pgwalk_pkg::ST_IDLE: begin
            if (head.valid && head.cmd.is_walk && first_ok) begin
               state_in = pgwalk_pkg::ST_WALK;
            end
         end
         pgwalk_pkg::ST_WALK: begin
            if (finish && rsp_free) begin
               state_in = pgwalk_pkg::ST_IDLE;
            end
         end
         default: state_in = pgwalk_pkg::ST_IDLE;
      endcase
   end

   // Outputs: memory access, queue pop and result load
   always_comb begin
      pop           = 1'b0;
      load          = 1'b0;
      result        = '0;
      ram_req.we    = 1'b0;
      ram_req.waddr = head.cmd.waddr;
      ram_req.wdata = head.cmd.wdata;
      ram_req.re    = 1'b0;
      ram_req.raddr = pgwalk_pkg::MEM_AW'(first_word);
      level_in      = level_ff;
      case (state_ff)
         pgwalk_pkg::ST_IDLE: begin
            if (head.valid) begin
               if (!head.cmd.is_walk) begin
                  ram_req.we = 1'b1;
                  pop        = 1'b1;
               end else if (!first_ok) begin
                  if (rsp_free) begin
                     load = 1'b1;
                     pop  = 1'b1;
                  end
               end else begin
                  ram_req.re = 1'b1;
                  level_in   = pgwalk_pkg::LVL_TOP;
               end
            end
         end
         pgwalk_pkg::ST_WALK: begin
            if (finish) begin
               if (rsp_free) begin
                  load = 1'b1;
                  pop  = 1'b1;
                  if (done_leaf) begin
                     result.found         = 1'b1;
                     result.machine_frame = leaf_frame;
                  end
               end
            end else begin
               ram_req.re    = 1'b1;
               ram_req.raddr = pgwalk_pkg::MEM_AW'(next_word);
               level_in      = level_ff - 2'd1;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rsp_data_in  = load ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pgwalk_pkg::ST_IDLE;
         level_ff     <= pgwalk_pkg::LVL_TOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;
   assign status.busy        = (state_ff == pgwalk_pkg::ST_WALK);
   assign status.result_load = load;

endmodule

>>> hw/rtl/four_level_page_table_walker.sv
// A translate request passes through the command queue, a top-level table read,
// one further table read per level walked and the response register.
// Walks run one at a time on dependent table memory reads, and an early miss
// ends one sooner; the queue takes new requests during a walk until it is full.
// Reset clears queue, walker state and response valid; the table memory is
// not cleared and holds undefined data until written.
// ----------------------------------------------------------------------------
// Four-level page table walker
// Translates guest frames to machine frames through four table levels held
// in a local table memory that write requests fill.
// ----------------------------------------------------------------------------
`include "four_level_page_table_walker_assert.svh"

module four_level_page_table_walker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pgwalk_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pgwalk_pkg::rsp_type rsp_data
);

   pgwalk_pkg::queue_head_type    queue_head;
   logic                          queue_pop;
   pgwalk_pkg::ram_req_type       ram_req;
   logic [pgwalk_pkg::WORD_W-1:0] ram_rdata;
   pgwalk_pkg::back_status_type   back_status;

   // Accept and queue requests
   pgwalk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .head      (queue_head),
      .pop       (queue_pop)
   );

   // Execute writes and walks
   pgwalk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (queue_head),
      .pop       (queue_pop),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (back_status)
   );

   // Table memory
   pgwalk_ram #(
      .WIDTH (pgwalk_pkg::WORD_W),
      .DEPTH (pgwalk_pkg::MEM_WORDS)
   ) u_table (
      .clock (clock),
      .we    (ram_req.we),
      .waddr (ram_req.waddr),
      .wdata (ram_req.wdata),
      .re    (ram_req.re),
      .raddr (ram_req.raddr),
      .rdata (ram_rdata)
   );

   // A walk in progress always has its command at the queue head
   `PGW_ASSERT_IMPL(a_walk_has_head, back_status.busy, queue_head.valid && queue_head.cmd.is_walk)
   // A table write retires the queued write in the same cycle
   `PGW_ASSERT_IMPL(a_write_pops, ram_req.we, queue_pop && !queue_head.cmd.is_walk)
   // A table read never coincides with a write or a retire
   `PGW_ASSERT_IMPL(a_read_alone, ram_req.re, !ram_req.we && !queue_pop)
   // A loaded result is presented in the next cycle
   `PGW_ASSERT_NEXT(a_load_shows, back_status.result_load, rsp_valid)

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-level page table walker testbench
// Fills the table memory with write requests and translates guest frames
// through it. Every translation's outcome is predicted from a shadow copy of
// the table memory when the request is accepted, and it is compared field by
// field with the responses in order. The generator keeps its own plan of the
// memory, so that no walk ever reads a word that was never written.
// ----------------------------------------------------------------------------
module testbench;

   localparam int RANDOM_PER_PHASE = 135;
   localparam int DRAIN_CYCLES     = 20;
   localparam int CYCLE_LIMIT      = 200000;

   localparam logic [pgwalk_pkg::WORD_W-1:0] PRESENT_FLAG =
      pgwalk_pkg::WORD_W'(1) << pgwalk_pkg::BIT_PRESENT;
   localparam logic [pgwalk_pkg::WORD_W-1:0] SIZE_FLAG =
      pgwalk_pkg::WORD_W'(1) << pgwalk_pkg::BIT_SIZE;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   pgwalk_pkg::req_type req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   pgwalk_pkg::rsp_type rsp_data;

   // Requests waiting for the driver and translations waiting for a response
   pgwalk_pkg::req_type request_queue[$];
   pgwalk_pkg::rsp_type translation_queue[$];

   // Table memory as seen at acceptance, and as planned by the generator
   logic [pgwalk_pkg::WORD_W-1:0] table_image[pgwalk_pkg::MEM_WORDS];
   logic [pgwalk_pkg::WORD_W-1:0] plan_image[pgwalk_pkg::MEM_WORDS];
   bit                            plan_written[pgwalk_pkg::MEM_WORDS];

   int                  send_idle_pct = 0;
   int                  stall_pct     = 0;
   int                  planned_count = 0;
   int                  error_count   = 0;
   int                  cycle_count   = 0;
   pgwalk_pkg::rsp_type expected_rsp;

   four_level_page_table_walker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Walk the tables of one memory copy. On the plan copy, stop at the first
   // word that was never written and hand its index back in hole.
   function automatic logic walk_tables(input bit on_plan,
                                        input logic [pgwalk_pkg::ROOT_W-1:0] root,
                                        input logic [pgwalk_pkg::GFN_W-1:0] gfn,
                                        output logic [pgwalk_pkg::FRAME_W-1:0] frame,
                                        output int hole);
      logic [pgwalk_pkg::TBL_W-1:0]  tbl;
      logic [pgwalk_pkg::WORD_W-1:0] entry;
      logic [pgwalk_pkg::WALK_W-1:0] word;
      logic                          hit;
      bit                            done;
      int                            lvl;
      tbl   = root[pgwalk_pkg::ROOT_W-1:pgwalk_pkg::PAGE_SH];
      frame = '0;
      hole  = -1;
      hit   = 1'b0;
      done  = 1'b0;
      for (lvl = int'(pgwalk_pkg::LVL_TOP); lvl >= int'(pgwalk_pkg::LVL_ONE) && !done;
           lvl--) begin
         word = {tbl, gfn[pgwalk_pkg::IDX_W*lvl +: pgwalk_pkg::IDX_W]};
         if (word >= pgwalk_pkg::WALK_W'(pgwalk_pkg::MEM_WORDS)) begin
            done = 1'b1;
         end else if (on_plan && !plan_written[word[pgwalk_pkg::MEM_AW-1:0]]) begin
            hole = int'(word);
            done = 1'b1;
         end else begin
            entry = on_plan ? plan_image[word[pgwalk_pkg::MEM_AW-1:0]]
                            : table_image[word[pgwalk_pkg::MEM_AW-1:0]];
            if (!entry[pgwalk_pkg::BIT_PRESENT]) begin
               done = 1'b1;
            end else if (lvl == int'(pgwalk_pkg::LVL_TWO) && entry[pgwalk_pkg::BIT_SIZE]) begin
               // 2 MB page: low guest frame bits add onto the page frame
               frame = pgwalk_pkg::FRAME_W'(entry[pgwalk_pkg::ROOT_W-1:pgwalk_pkg::PAGE_SH]) +
                       pgwalk_pkg::FRAME_W'(gfn[pgwalk_pkg::IDX_W-1:0]);
               hit   = 1'b1;
               done  = 1'b1;
            end else if (lvl == int'(pgwalk_pkg::LVL_ONE)) begin
               frame = pgwalk_pkg::FRAME_W'(entry[pgwalk_pkg::ROOT_W-1:pgwalk_pkg::PAGE_SH]);
               hit   = 1'b1;
               done  = 1'b1;
            end else begin
               tbl = entry[pgwalk_pkg::ROOT_W-1:pgwalk_pkg::PAGE_SH];
            end
         end
      end
      return hit;
   endfunction

   function automatic logic [pgwalk_pkg::WORD_W-1:0] table_entry(
      input logic [pgwalk_pkg::TBL_W-1:0] tbl);
      return pgwalk_pkg::WORD_W'(tbl) << pgwalk_pkg::PAGE_SH;
   endfunction

   // Mostly present entries that point back into the memory
   function automatic logic [pgwalk_pkg::WORD_W-1:0] random_entry();
      logic [pgwalk_pkg::WORD_W-1:0] e;
      e = {$urandom, $urandom};
      e[pgwalk_pkg::BIT_PRESENT] = ($urandom_range(0, 9) != 0);
      e[pgwalk_pkg::BIT_SIZE]    = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0)
         e[pgwalk_pkg::ROOT_W-1:pgwalk_pkg::PAGE_SH] =
            pgwalk_pkg::TBL_W'($urandom_range(0, pgwalk_pkg::MEM_WORDS / 512 - 1));
      return e;
   endfunction

   task automatic queue_write(input logic [pgwalk_pkg::WADDR_W-1:0] addr,
                              input logic [pgwalk_pkg::WORD_W-1:0] data);
      pgwalk_pkg::req_type r;
      r.opcode       = pgwalk_pkg::OPC_WRITE;
      r.word_address = addr;
      r.write_data   = data;
      r.root_address = pgwalk_pkg::ROOT_W'({$urandom, $urandom});
      r.guest_frame  = pgwalk_pkg::GFN_W'({$urandom, $urandom});
      plan_image[addr]   = data;
      plan_written[addr] = 1'b1;
      request_queue.push_back(r);
      planned_count++;
   endtask

   // Fill every unwritten word the walk would touch, then queue the translate
   task automatic queue_translate(input logic [pgwalk_pkg::ROOT_W-1:0] root,
                                  input logic [pgwalk_pkg::GFN_W-1:0] gfn);
      pgwalk_pkg::req_type            r;
      logic [pgwalk_pkg::FRAME_W-1:0] frame;
      logic                           hit;
      int                             hole;
      hit = walk_tables(1'b1, root, gfn, frame, hole);
      while (hole >= 0) begin
         queue_write(pgwalk_pkg::WADDR_W'(hole), random_entry());
         hit = walk_tables(1'b1, root, gfn, frame, hole);
      end
      r.opcode       = pgwalk_pkg::OPC_WALK;
      r.word_address = pgwalk_pkg::WADDR_W'($urandom);
      r.write_data   = {$urandom, $urandom};
      r.root_address = root;
      r.guest_frame  = gfn;
      request_queue.push_back(r);
      planned_count++;
   endtask

   task automatic queue_random_item();
      logic [pgwalk_pkg::ROOT_W-1:0] root;
      logic [pgwalk_pkg::GFN_W-1:0]  gfn;
      int                            pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         // noise: overwrite any word, sometimes with an arbitrary value
         if ($urandom_range(0, 1) == 0)
            queue_write(pgwalk_pkg::WADDR_W'($urandom), random_entry());
         else
            queue_write(pgwalk_pkg::WADDR_W'($urandom), {$urandom, $urandom});
      end else if (pick < 20) begin
         // root far outside the memory
         root = pgwalk_pkg::ROOT_W'({$urandom, $urandom});
         if (root[pgwalk_pkg::ROOT_W-1:pgwalk_pkg::PAGE_SH+3] == '0)
            root[pgwalk_pkg::ROOT_W-1] = 1'b1;
         queue_translate(root, pgwalk_pkg::GFN_W'({$urandom, $urandom}));
      end else begin
         // well-formed walk; small indices favor reuse of existing tables
         root = pgwalk_pkg::ROOT_W'({$urandom, $urandom});
         root[pgwalk_pkg::ROOT_W-1:pgwalk_pkg::PAGE_SH] =
            pgwalk_pkg::TBL_W'($urandom_range(0, pgwalk_pkg::MEM_WORDS / 512 - 1));
         for (int i = 0; i < 4; i++)
            gfn[pgwalk_pkg::IDX_W*i +: pgwalk_pkg::IDX_W] = ($urandom_range(0, 3) == 0) ?
               pgwalk_pkg::IDX_W'($urandom) : pgwalk_pkg::IDX_W'($urandom_range(0, 3));
         queue_translate(root, gfn);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   task automatic predict_request(input pgwalk_pkg::req_type r);
      pgwalk_pkg::rsp_type            t;
      logic [pgwalk_pkg::FRAME_W-1:0] frame;
      int                             hole;
      if (r.opcode == pgwalk_pkg::OPC_WRITE) begin
         table_image[r.word_address] = r.write_data;
      end else begin
         t.found         = walk_tables(1'b0, r.root_address, r.guest_frame, frame, hole);
         t.machine_frame = frame;
         translation_queue.push_back(t);
      end
   endtask

   // Request driver: predict on acceptance, then present the next request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_request(req_data);
         if (!req_valid || !req_stall) begin
            if (request_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= request_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check against the oldest translation, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (translation_queue.size() == 0) begin
               report_mismatch("unexpected response", 64'(rsp_data), 64'd0);
            end else begin
               expected_rsp = translation_queue.pop_front();
               if (rsp_data.found !== expected_rsp.found)
                  report_mismatch("found", 64'(rsp_data.found), 64'(expected_rsp.found));
               if (rsp_data.machine_frame !== expected_rsp.machine_frame)
                  report_mismatch("machine_frame", 64'(rsp_data.machine_frame),
                                  64'(expected_rsp.machine_frame));
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[four_level_page_table_walker] ERROR");
         $finish;
      end
   end

   initial begin
      int phase;
      int target;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 20;
               stall_pct     = 80;
            end
            1: begin
               send_idle_pct = 80;
               stall_pct     = 20;
            end
            default: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
         endcase
         if (phase == 0) begin
            // chain of tables 0 -> 1 -> 2 -> 3 ending in the largest leaf frame
            queue_write(12'd0, table_entry(40'd1) | PRESENT_FLAG);
            queue_write(12'd512, table_entry(40'd2) | PRESENT_FLAG);
            queue_write(12'd1024, table_entry(40'd3) | PRESENT_FLAG);
            queue_write(12'd1536, table_entry('1) | PRESENT_FLAG);
            queue_translate(52'h0, 36'h0);
            // 2 MB page with the largest frame and the largest offset
            queue_write(12'd1025, table_entry('1) | PRESENT_FLAG | SIZE_FLAG);
            queue_translate(52'h0, 36'h3ff);
            // leaf not present, every other bit set
            queue_write(12'd1541, ~PRESENT_FLAG);
            queue_translate(52'h0, 36'h5);
            // level three points just past the memory
            queue_write(12'd513, table_entry(40'd8) | PRESENT_FLAG);
            queue_translate(52'h0, 36'h1 << 18);
            // size bit at level three is ignored
            queue_write(12'd514, table_entry(40'd2) | PRESENT_FLAG | SIZE_FLAG);
            queue_translate(52'h0, 36'h2 << 18);
            // unaligned root and root beyond the memory
            queue_translate(52'hfff, 36'h0);
            queue_translate('1, 36'h0);
            // all-zero entry
            queue_write(12'd1542, 64'h0);
            queue_translate(52'h0, 36'h6);
            // last word of the last table as the top level
            queue_write(12'hfff, table_entry(40'd0) | PRESENT_FLAG);
            queue_translate(52'h7000, 36'h1ff << 27);
            queue_write(12'hfff, '1);
            queue_translate(52'h7000, 36'h1ff << 27);
            queue_translate(52'h0, '1);
         end
         target = planned_count + RANDOM_PER_PHASE;
         while (planned_count < target)
            queue_random_item();
         // hold off new requests until every translation has answered
         while (request_queue.size() > 0 || req_valid || translation_queue.size() > 0)
            @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("[four_level_page_table_walker] OK");
      end else begin
         $display("[four_level_page_table_walker] ERROR");
      end
      $finish;
   end

endmodule

>>> four_level_page_table_walker.f
+incdir+hw/rtl
hw/rtl/pgwalk_pkg.sv
hw/rtl/pgwalk_ram.sv
hw/rtl/pgwalk_front.sv
hw/rtl/pgwalk_back.sv
hw/rtl/four_level_page_table_walker.sv
test/testbench.sv
